FILE: design/crsr_pkg.sv
`default_nettype none

package crsr_pkg;

   localparam int BUFFER_BYTES = 65536;

   localparam int FUNC_W     = 2;
   localparam int NBYTES_W   = 17;
   localparam int POSITION_W = 16;
   localparam int COUNT_W    = 17;
   localparam int SLOW_W     = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_RESERVE = 2'd0,
      FUNC_COMMIT  = 2'd1,
      FUNC_PEEK    = 2'd2,
      FUNC_CONSUME = 2'd3
   } func_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

`default_nettype wire

FILE: design/crsr_ctrl.sv
`default_nettype none

module crsr_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output crsr_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HOLD
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               state_ff     <= ST_HOLD;
               rsp_valid_ff <= 1'b1;
            end
            ST_HOLD: begin
               if (rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign cmd.load  = req_valid & req_ready_ff;
   assign cmd.exec  = (state_ff == ST_EXEC);

endmodule

`default_nettype wire

FILE: design/crsr_datapath.sv
`default_nettype none

module crsr_datapath #(
   parameter int BUFFER_BYTES = crsr_pkg::BUFFER_BYTES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire crsr_pkg::cmd_type              cmd,
   input  wire logic [crsr_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [crsr_pkg::NBYTES_W-1:0]  req_nbytes,
   output logic                                rsp_granted,
   output logic [crsr_pkg::POSITION_W-1:0]     rsp_position,
   output logic [crsr_pkg::COUNT_W-1:0]        rsp_byte_count,
   output logic [crsr_pkg::SLOW_W-1:0]         rsp_slow_path_count
);

   localparam int OFS_W = $clog2(BUFFER_BYTES + 1);
   localparam int CW    = (OFS_W > crsr_pkg::NBYTES_W) ? OFS_W : crsr_pkg::NBYTES_W;
   localparam logic [OFS_W-1:0] BUF_W = OFS_W'(BUFFER_BYTES);

   crsr_pkg::func_type              func_ff;
   logic [crsr_pkg::NBYTES_W-1:0]   nbytes_ff;

   logic [OFS_W-1:0]  prod_ff, prod_in;
   logic [OFS_W-1:0]  cons_ff, cons_in;
   logic [OFS_W-1:0]  rec_ff, rec_in;
   logic [OFS_W-1:0]  hint_ff, hint_in;
   logic [crsr_pkg::SLOW_W-1:0] cnt_ff, cnt_in;

   logic                             granted_ff, granted_in;
   logic [crsr_pkg::POSITION_W-1:0]  position_ff, position_in;
   logic [crsr_pkg::COUNT_W-1:0]     count_ff, count_in;

   logic [CW-1:0]     n_x;
   logic [OFS_W-1:0]  tail;
   logic [OFS_W-1:0]  lim;
   logic [OFS_W-1:0]  avail;
   logic [OFS_W-1:0]  step;
   logic [OFS_W-1:0]  pos_v;
   logic [OFS_W-1:0]  count_v;
   logic [31:0]       pos_wide;
   logic [31:0]       count_wide;

   assign n_x = CW'(nbytes_ff);

   always_comb begin
      prod_in    = prod_ff;
      cons_in    = cons_ff;
      rec_in     = rec_ff;
      hint_in    = hint_ff;
      cnt_in     = cnt_ff;
      granted_in = 1'b1;
      tail       = BUF_W - prod_ff;
      lim        = (hint_ff == '0) ? '0 : hint_ff - OFS_W'(1);
      avail      = '0;
      step       = '0;
      pos_v      = '0;
      count_v    = '0;
      case (func_ff)
         crsr_pkg::FUNC_RESERVE: begin
            if (CW'(hint_ff) <= n_x) begin
               if (cons_ff <= prod_ff) begin
                  hint_in = tail;
                  if (CW'(tail) <= n_x) begin
                     rec_in = prod_ff;
                     if (cons_ff != '0) begin
                        prod_in = '0;
                        hint_in = cons_ff;
                     end
                  end
               end else begin
                  hint_in = cons_ff - prod_ff;
               end
               if (CW'(hint_in) <= n_x) begin
                  granted_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            pos_v   = prod_in;
            count_v = hint_in;
         end
         crsr_pkg::FUNC_COMMIT: begin
            step    = (n_x > CW'(lim)) ? lim : n_x[OFS_W-1:0];
            prod_in = prod_ff + step;
            hint_in = hint_ff - step;
            pos_v   = prod_in;
            count_v = hint_in;
         end
         crsr_pkg::FUNC_PEEK: begin
            if (prod_ff < cons_ff) begin
               count_v = (rec_ff > cons_ff) ? rec_ff - cons_ff : '0;
               if (count_v == '0) begin
                  cons_in = '0;
                  count_v = prod_ff;
               end
            end else begin
               count_v = prod_ff - cons_ff;
            end
            pos_v = cons_in;
         end
         crsr_pkg::FUNC_CONSUME: begin
            if (prod_ff >= cons_ff) begin
               avail = prod_ff - cons_ff;
            end else if (rec_ff > cons_ff) begin
               avail = rec_ff - cons_ff;
            end else begin
               avail = '0;
            end
            step    = (n_x > CW'(avail)) ? avail : n_x[OFS_W-1:0];
            cons_in = cons_ff + step;
            pos_v   = cons_in;
            count_v = hint_ff;
         end
         default: begin
            pos_v   = prod_ff;
            count_v = hint_ff;
         end
      endcase
      pos_wide    = 32'(pos_v);
      count_wide  = 32'(count_v);
      position_in = pos_wide[crsr_pkg::POSITION_W-1:0];
      count_in    = count_wide[crsr_pkg::COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= crsr_pkg::func_type'(req_func);
         nbytes_ff <= req_nbytes;
      end
      if (cmd.exec) begin
         granted_ff  <= granted_in;
         position_ff <= position_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= '0;
         cons_ff <= '0;
         rec_ff  <= BUF_W;
         hint_ff <= BUF_W;
         cnt_ff  <= '0;
      end else if (cmd.exec) begin
         prod_ff <= prod_in;
         cons_ff <= cons_in;
         rec_ff  <= rec_in;
         hint_ff <= hint_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign rsp_granted         = granted_ff;
   assign rsp_position        = position_ff;
   assign rsp_byte_count      = count_ff;
   assign rsp_slow_path_count = cnt_ff;

endmodule

`default_nettype wire

FILE: design/contiguous_ring_space_reserver.sv
// A word accepted in the idle state is executed in the execute state, which
// registers its result on rsp_ and raises rsp_valid.
// The controller walks accept, execute and hold for each word and takes no new
// word until rsp_ready has taken the held result; all offsets are settled in
// the execute state.
// Reset (synchronous, active high): offsets cleared, recorded end and free
// space set to the buffer size, slow-path count cleared, no result pending.
`default_nettype none

module contiguous_ring_space_reserver #(
   parameter int BUFFER_BYTES = crsr_pkg::BUFFER_BYTES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [crsr_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [crsr_pkg::NBYTES_W-1:0]  req_nbytes,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_granted,
   output logic [crsr_pkg::POSITION_W-1:0]     rsp_position,
   output logic [crsr_pkg::COUNT_W-1:0]        rsp_byte_count,
   output logic [crsr_pkg::SLOW_W-1:0]         rsp_slow_path_count
);

   crsr_pkg::cmd_type cmd;

   crsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   crsr_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_func            (req_func),
      .req_nbytes          (req_nbytes),
      .rsp_granted         (rsp_granted),
      .rsp_position        (rsp_position),
      .rsp_byte_count      (rsp_byte_count),
      .rsp_slow_path_count (rsp_slow_path_count)
   );

endmodule

`default_nettype wire
